>>> rtl/hftw_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies; every other file imports this package.
package hftw_pkg;

    localparam int unsigned NODE_W       = 9;
    localparam int unsigned ADDR_W       = 8;
    localparam int unsigned POS_W        = 10;
    localparam int unsigned SYM_W        = 8;
    localparam int unsigned BYTE_BITS    = 8;
    localparam int unsigned BITCNT_W     = 4;
    localparam int unsigned TABLE_DEPTH  = 255;
    localparam int unsigned NUM_SYMBOLS_DEF = 256;

    localparam logic [NODE_W-1:0] ROOT_NODE    = 9'd510;
    localparam logic [NODE_W-1:0] INNER_BASE   = 9'd256;
    localparam logic [POS_W-1:0]  HEADER_CODES = 10'd510;
    localparam logic [POS_W-1:0]  COUNT_POS    = 10'd511;
    localparam logic [POS_W-1:0]  DATA_POS     = 10'd512;
    localparam logic [ADDR_W-1:0] NO_PARENT    = 8'd255;
    localparam logic [2:0]        MAX_TAIL     = 3'd7;

    typedef enum logic [1:0] {
        WS_IDLE,
        WS_STEP,
        WS_FLUSH
    } t_walk_state;

    // Request from the byte front end to the tree walker.
    typedef struct packed {
        logic                start;
        logic [SYM_W-1:0]    data;
        logic [BITCNT_W-1:0] nbits;
        logic                eos;
    } t_walk_start;

    // Header-phase write into the child tables.
    typedef struct packed {
        logic              left_we;
        logic              right_we;
        logic [ADDR_W-1:0] addr;
        logic [NODE_W-1:0] data;
    } t_child_wr;

endpackage

>>> rtl/hftw_child_mem.sv
// Child tables of the decoding tree: one left and one right memory, 255 x 9 bits.
// Depends on hftw_pkg. Synchronous write, registered read.
module hftw_child_mem
    import hftw_pkg::*;
(
    input  logic              i_clk,
    input  t_child_wr         i_wr,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [NODE_W-1:0] o_rd_left,
    output logic [NODE_W-1:0] o_rd_right
);

    logic [NODE_W-1:0] r_left_mem  [0:TABLE_DEPTH-1];
    logic [NODE_W-1:0] r_right_mem [0:TABLE_DEPTH-1];
    logic [NODE_W-1:0] r_rd_left;
    logic [NODE_W-1:0] r_rd_right;

    always_ff @(posedge i_clk) begin
        if (i_wr.left_we) begin
            r_left_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_wr.right_we) begin
            r_right_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // The read data holds while no read is issued, so a stalled walk keeps its operand.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_left  <= r_left_mem[i_rd_addr];
            r_rd_right <= r_right_mem[i_rd_addr];
        end
    end

    assign o_rd_left  = r_rd_left;
    assign o_rd_right = r_rd_right;

endmodule

>>> rtl/hftw_walker.sv
// Tree walker: steps one bit per cycle through the child tables, unless the output is full, and emits symbols.
// Depends on hftw_pkg; reads the tables held in hftw_child_mem.
module hftw_walker
    import hftw_pkg::*;
#(
    parameter int unsigned P_NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_walk_start       i_start,
    output logic              o_idle,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [NODE_W-1:0] i_rd_left,
    input  logic [NODE_W-1:0] i_rd_right,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [SYM_W-1:0]  m_axis_tdata,   // [7:0] symbol
    output logic              m_axis_tlast,   // last_of_item
    output logic              m_axis_tuser    // [0] end_of_stream
);

    t_walk_state         r_state, n_state;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [SYM_W-1:0]    r_data, n_data;
    logic [BITCNT_W-1:0] r_bits, n_bits;
    logic                r_eos, n_eos;
    logic                r_pend_vld, n_pend_vld;
    logic [SYM_W-1:0]    r_pend_sym, n_pend_sym;
    logic                r_out_vld, n_out_vld;
    logic [SYM_W-1:0]    r_out_sym, n_out_sym;
    logic                r_out_last, n_out_last;
    logic                r_out_eos, n_out_eos;

    logic [NODE_W-1:0]   child;
    logic                is_leaf;
    logic                emit;
    logic                out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= WS_IDLE;
            r_node     <= ROOT_NODE;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_node     <= n_node;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_bits     <= n_bits;
        r_eos      <= n_eos;
        r_pend_sym <= n_pend_sym;
        r_out_sym  <= n_out_sym;
        r_out_last <= n_out_last;
        r_out_eos  <= n_out_eos;
    end

    always_comb begin
        child    = r_data[BYTE_BITS-1] ? i_rd_right : i_rd_left;
        is_leaf  = (child < INNER_BASE);
        emit     = is_leaf && (child < NODE_W'(P_NUM_SYMBOLS));
        out_free = !r_out_vld || m_axis_tready;

        n_state    = r_state;
        n_node     = r_node;
        n_data     = r_data;
        n_bits     = r_bits;
        n_eos      = r_eos;
        n_pend_vld = r_pend_vld;
        n_pend_sym = r_pend_sym;
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_out_sym  = r_out_sym;
        n_out_last = r_out_last;
        n_out_eos  = r_out_eos;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_node[ADDR_W-1:0];

        unique case (r_state)
            WS_IDLE: begin
                if (i_start.start) begin
                    n_data = i_start.data;
                    n_bits = i_start.nbits;
                    n_eos  = i_start.eos;
                    if (i_start.nbits == '0) begin
                        n_state = WS_FLUSH;
                    end else begin
                        o_rd_en = 1'b1;
                        n_state = WS_STEP;
                    end
                end
            end
            WS_STEP: begin
                // A new symbol pushes the held one out; wait if the output is still full.
                if (!(emit && r_pend_vld && !out_free)) begin
                    if (emit) begin
                        if (r_pend_vld) begin
                            n_out_vld  = 1'b1;
                            n_out_sym  = r_pend_sym;
                            n_out_last = 1'b0;
                            n_out_eos  = r_eos;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_sym = child[SYM_W-1:0];
                    end
                    n_node = is_leaf ? ROOT_NODE : child;
                    n_data = {r_data[BYTE_BITS-2:0], 1'b0};
                    n_bits = r_bits - BITCNT_W'(1);
                    if (n_bits == '0) begin
                        n_state = WS_FLUSH;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = n_node[ADDR_W-1:0];
                    end
                end
            end
            WS_FLUSH: begin
                if (!r_pend_vld || out_free) begin
                    if (r_pend_vld) begin
                        n_out_vld  = 1'b1;
                        n_out_sym  = r_pend_sym;
                        n_out_last = 1'b1;
                        n_out_eos  = r_eos;
                        n_pend_vld = 1'b0;
                    end
                    // End of file drops any partly walked code.
                    if (r_eos) begin
                        n_node = ROOT_NODE;
                    end
                    n_state = WS_IDLE;
                end
            end
            default: begin
                n_state = WS_IDLE;
            end
        endcase
    end

    assign o_idle        = (r_state == WS_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_sym;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_eos;

endmodule

>>> rtl/huffman_tree_walk_decoder.sv
// Huffman tree-walk decoder top level; depends on hftw_pkg, hftw_child_mem, hftw_walker.
// A header byte is taken whenever the walker is idle. A data byte starts a walk
// of nbits tree steps (eight for an ordinary byte), one read of the child memories per
// bit, and no new byte is taken until the walker is idle again; output stalls hold it.
// A decoded symbol waits until the next symbol or the end of the byte pushes it out.
// Reset (synchronous, active low) returns to header phase with the root as current node.
module huffman_tree_walk_decoder
    import hftw_pkg::*;
#(
    parameter int unsigned P_NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [SYM_W-1:0] s_axis_tdata,   // [7:0] file_byte
    input  logic             s_axis_tlast,   // final_byte
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [SYM_W-1:0] m_axis_tdata,   // [7:0] symbol
    output logic             m_axis_tlast,   // last_of_item
    output logic             m_axis_tuser    // [0] end_of_stream
);

    // Header state. The byte position saturates once the data phase is reached.
    // The left-filled flags are kept in flip-flops so the end of a file clears them
    // at once; the child tables themselves are never cleared, since a tree built
    // from a well-formed header writes every entry the walk can reach.
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [2:0]             r_tail, n_tail;
    logic [TABLE_DEPTH-1:0] r_filled, n_filled;

    logic        accept;
    logic        header;
    logic        code_ok;
    logic        walk_idle;
    t_walk_start walk_start;
    t_child_wr   child_wr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [NODE_W-1:0] rd_left;
    logic [NODE_W-1:0] rd_right;

    // Input is taken only while the walker is idle, so header writes and walk reads
    // of the child memories never overlap and need no forwarding.
    assign s_axis_tready = walk_idle;
    assign accept        = s_axis_tvalid && walk_idle;
    assign header        = (r_pos < DATA_POS);
    assign code_ok       = (r_pos < HEADER_CODES) && (s_axis_tdata != NO_PARENT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_tail   <= '0;
            r_filled <= '0;
        end else begin
            r_pos    <= n_pos;
            r_tail   <= n_tail;
            r_filled <= n_filled;
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_tail   = r_tail;
        n_filled = r_filled;

        child_wr.left_we  = 1'b0;
        child_wr.right_we = 1'b0;
        child_wr.addr     = s_axis_tdata;
        child_wr.data     = r_pos[NODE_W-1:0];

        walk_start.start = accept && !header;
        walk_start.data  = s_axis_tdata;
        walk_start.nbits = s_axis_tlast ? {1'b0, r_tail} : BITCNT_W'(BYTE_BITS);
        walk_start.eos   = s_axis_tlast;

        if (accept && header) begin
            // The first child of a parent goes left; every later one overwrites right.
            if (code_ok) begin
                if (!r_filled[s_axis_tdata]) begin
                    child_wr.left_we         = 1'b1;
                    n_filled[s_axis_tdata]   = 1'b1;
                end else begin
                    child_wr.right_we = 1'b1;
                end
            end
            if (r_pos == COUNT_POS) begin
                n_tail = (s_axis_tdata > SYM_W'(MAX_TAIL)) ? MAX_TAIL : s_axis_tdata[2:0];
            end
            n_pos = r_pos + POS_W'(1);
        end

        // End of file in either phase: back to header phase with an empty tree.
        if (accept && s_axis_tlast) begin
            n_pos    = '0;
            n_tail   = '0;
            n_filled = '0;
        end
    end

    hftw_child_mem u_child_mem (
        .i_clk      (i_clk),
        .i_wr       (child_wr),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_left  (rd_left),
        .o_rd_right (rd_right)
    );

    hftw_walker #(
        .P_NUM_SYMBOLS (P_NUM_SYMBOLS)
    ) u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (walk_start),
        .o_idle        (walk_idle),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_left     (rd_left),
        .i_rd_right    (rd_right),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
